/* sv/jslm_pkg.sv */
// Shared types and constants for the joint safety limit monitor.
package jslm_pkg;

    localparam int JOINT_COUNT  = 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int JOINT_W      = 3;
    localparam int IDX_W        = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int ERR_W        = 11;
    localparam int HW_W         = 8;
    localparam int CNT_W        = 8;

    localparam int ERR_VEL_BIT   = 8;
    localparam int ERR_CUR_BIT   = 9;
    localparam int ERR_UNREACH_BIT = 10;

    localparam logic [CNT_W-1:0] READ_FAIL_LIMIT_RST = CNT_W'(10);

    typedef enum logic [1:0] {
        REQ_SAMPLE    = 2'd0,
        REQ_READ_FAIL = 2'd1,
        REQ_RESET     = 2'd2,
        REQ_LOAD      = 2'd3
    } t_req;

    typedef struct packed {
        logic vel_over;
        logic cur_over;
    } t_limit_flags;

    typedef struct packed {
        logic [JOINT_W-1:0] joint_out;
        logic [ERR_W-1:0]   error_bits;
        logic               violation;
        logic               stop_request;
    } t_result;

    function automatic logic joint_in_range(input logic [JOINT_W-1:0] joint);
        return ({2'b00, joint} < (JOINT_W + 2)'(JOINT_COUNT));
    endfunction

endpackage

/* sv/jslm_limit_check.sv */
// Per-joint limit tables and the absolute-value limit compares.
module jslm_limit_check
    import jslm_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_advance,
    input  t_req                           i_req,
    input  logic [JOINT_W-1:0]             i_joint,
    input  logic signed [SAMPLE_WIDTH-1:0] i_velocity,
    input  logic signed [SAMPLE_WIDTH-1:0] i_motor_current,
    output t_limit_flags                   o_flags
);

    logic signed [SAMPLE_WIDTH-1:0] r_vel_limit [JOINT_COUNT];
    logic signed [SAMPLE_WIDTH-1:0] r_cur_limit [JOINT_COUNT];

    logic [IDX_W-1:0]        idx;
    logic                    jvalid;
    logic [SAMPLE_WIDTH:0]   vel_abs;
    logic [SAMPLE_WIDTH:0]   cur_abs;
    logic signed [SAMPLE_WIDTH-1:0] vel_lim;
    logic signed [SAMPLE_WIDTH-1:0] cur_lim;

    assign idx    = IDX_W'(i_joint);
    assign jvalid = joint_in_range(i_joint);

    always_ff @(posedge i_clk) begin
        if (i_advance && (i_req == REQ_LOAD) && jvalid) begin
            r_vel_limit[idx] <= i_velocity;
            r_cur_limit[idx] <= i_motor_current;
        end
    end

    // exact magnitude, one bit wider so that the most negative value fits
    always_comb begin
        vel_abs = i_velocity[SAMPLE_WIDTH-1]
                ? (SAMPLE_WIDTH+1)'(-$signed({i_velocity[SAMPLE_WIDTH-1], i_velocity}))
                : {1'b0, i_velocity};
        cur_abs = i_motor_current[SAMPLE_WIDTH-1]
                ? (SAMPLE_WIDTH+1)'(-$signed({i_motor_current[SAMPLE_WIDTH-1], i_motor_current}))
                : {1'b0, i_motor_current};
        vel_lim = r_vel_limit[idx];
        cur_lim = r_cur_limit[idx];
        // a negative limit is exceeded by any magnitude
        o_flags.vel_over = vel_lim[SAMPLE_WIDTH-1] || (vel_abs > {1'b0, vel_lim});
        o_flags.cur_over = cur_lim[SAMPLE_WIDTH-1] || (cur_abs > {1'b0, cur_lim});
    end

endmodule

/* sv/jslm_err_state.sv */
// Sticky error words, violation latch, read-failure counter and stop one-shot.
module jslm_err_state
    import jslm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  t_req               i_req,
    input  logic [JOINT_W-1:0] i_joint,
    input  logic [HW_W-1:0]    i_hw_error,
    input  t_limit_flags       i_flags,
    input  logic [CNT_W-1:0]   i_read_fail_limit,
    output t_result            o_result
);

    logic [ERR_W-1:0] r_words [JOINT_COUNT];
    logic [ERR_W-1:0] n_words [JOINT_COUNT];
    logic             r_latch, n_latch;
    logic             r_stop_issued, n_stop_issued;
    logic [CNT_W-1:0] r_count, n_count;

    logic [IDX_W-1:0] idx;
    logic             jvalid;
    logic [ERR_W-1:0] word_j;
    logic [ERR_W-1:0] w_new;
    logic [CNT_W:0]   cnt_inc;

    assign idx    = IDX_W'(i_joint);
    assign jvalid = joint_in_range(i_joint);
    assign word_j = r_words[idx];

    always_comb begin
        n_words       = r_words;
        n_latch       = r_latch;
        n_stop_issued = r_stop_issued;
        n_count       = r_count;
        cnt_inc       = {1'b0, r_count} + (CNT_W+1)'(1);
        w_new         = word_j | ERR_W'(i_hw_error);
        if (i_flags.vel_over) w_new[ERR_VEL_BIT] = 1'b1;
        if (i_flags.cur_over) w_new[ERR_CUR_BIT] = 1'b1;

        o_result.joint_out    = i_joint;
        o_result.error_bits   = '0;
        o_result.stop_request = 1'b0;

        // stop one-shot looks at the latch as it stood on arrival
        if ((i_req == REQ_SAMPLE) || (i_req == REQ_READ_FAIL)) begin
            if (r_latch) begin
                if (!r_stop_issued) begin
                    o_result.stop_request = 1'b1;
                    n_stop_issued         = 1'b1;
                end
            end else begin
                n_stop_issued = 1'b0;
            end
        end

        case (i_req)
            REQ_SAMPLE: begin
                if (jvalid) begin
                    n_words[idx] = w_new;
                    if ((i_hw_error != '0) || i_flags.vel_over || i_flags.cur_over)
                        n_latch = 1'b1;
                    n_count             = '0;
                    o_result.error_bits = w_new;
                end
            end
            REQ_READ_FAIL: begin
                o_result.joint_out = '0;
                if (!r_latch) begin
                    if (cnt_inc > {1'b0, i_read_fail_limit}) begin
                        n_latch                     = 1'b1;
                        n_words[0][ERR_UNREACH_BIT] = 1'b1;
                        n_count                     = '0;
                    end else begin
                        n_count = cnt_inc[CNT_W-1:0];
                    end
                end
                o_result.error_bits = n_words[0];
            end
            REQ_RESET: begin
                for (int i = 0; i < JOINT_COUNT; i++)
                    n_words[i] = '0;
                n_latch            = 1'b0;
                o_result.joint_out = '0;
            end
            REQ_LOAD: begin
                if (jvalid)
                    o_result.error_bits = word_j;
            end
            default: begin
                o_result.joint_out = i_joint;
            end
        endcase

        o_result.violation = n_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < JOINT_COUNT; i++)
                r_words[i] <= '0;
            r_latch       <= 1'b0;
            r_stop_issued <= 1'b0;
            r_count       <= '0;
        end else if (i_advance) begin
            r_words       <= n_words;
            r_latch       <= n_latch;
            r_stop_issued <= n_stop_issued;
            r_count       <= n_count;
        end
    end

endmodule

/* sv/joint_safety_limit_monitor_top.sv */
// Top level: request register, limit check, error state and result register.
// The request register holds a request; the result register holds its result for o_valid.
// Throughput: one request per cycle while i_stall is low; the request register feeds
// the result register through one pass of compare and OR logic; both stages move together.
// Reset (synchronous, active low) clears error words, latch, counters and valids and
// sets read_fail_limit to 10; limit tables hold no value until loaded.
module joint_safety_limit_monitor_top
    import jslm_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_req_type,
    input  logic [JOINT_W-1:0]             i_joint,
    input  logic signed [SAMPLE_WIDTH-1:0] i_velocity,
    input  logic signed [SAMPLE_WIDTH-1:0] i_motor_current,
    input  logic [HW_W-1:0]                i_hw_error,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CNT_W-1:0]               i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [JOINT_W-1:0]             o_joint_out,
    output logic [ERR_W-1:0]               o_error_bits,
    output logic                           o_violation,
    output logic                           o_stop_request
);

    logic                           r_s1_valid;
    t_req                           r_req;
    logic [JOINT_W-1:0]             r_joint;
    logic signed [SAMPLE_WIDTH-1:0] r_velocity;
    logic signed [SAMPLE_WIDTH-1:0] r_motor_current;
    logic [HW_W-1:0]                r_hw_error;
    logic [CNT_W-1:0]               r_read_fail_limit;
    logic                           r_out_valid;
    t_result                        r_result;

    logic         advance;
    logic         accept;
    t_limit_flags flags;
    t_result      result;

    assign advance     = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_s1_valid && !advance;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_read_fail_limit <= READ_FAIL_LIMIT_RST;
        end else begin
            if (accept)
                r_s1_valid <= 1'b1;
            else if (advance)
                r_s1_valid <= 1'b0;
            if (advance)
                r_out_valid <= 1'b1;
            else if (!i_stall)
                r_out_valid <= 1'b0;
            if (i_cfg_valid)
                r_read_fail_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req           <= t_req'(i_req_type);
            r_joint         <= i_joint;
            r_velocity      <= i_velocity;
            r_motor_current <= i_motor_current;
            r_hw_error      <= i_hw_error;
        end
        if (advance)
            r_result <= result;
    end

    jslm_limit_check u_limit_check (
        .i_clk           (i_clk),
        .i_advance       (advance),
        .i_req           (r_req),
        .i_joint         (r_joint),
        .i_velocity      (r_velocity),
        .i_motor_current (r_motor_current),
        .o_flags         (flags)
    );

    jslm_err_state u_err_state (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (advance),
        .i_req             (r_req),
        .i_joint           (r_joint),
        .i_hw_error        (r_hw_error),
        .i_flags           (flags),
        .i_read_fail_limit (r_read_fail_limit),
        .o_result          (result)
    );

    assign o_valid        = r_out_valid;
    assign o_joint_out    = r_result.joint_out;
    assign o_error_bits   = r_result.error_bits;
    assign o_violation    = r_result.violation;
    assign o_stop_request = r_result.stop_request;

endmodule

/* verif/jslm_checker.sv */
// Scoreboard for the joint safety limit monitor: predicts each report and checks it.
module jslm_checker
    import jslm_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_stall,
    input  logic [1:0]                     i_req_type,
    input  logic [JOINT_W-1:0]             i_joint,
    input  logic signed [SAMPLE_WIDTH-1:0] i_velocity,
    input  logic signed [SAMPLE_WIDTH-1:0] i_motor_current,
    input  logic [HW_W-1:0]                i_hw_error,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [CNT_W-1:0]               i_cfg_data,
    input  logic                           i_res_valid,
    input  logic                           i_res_stall,
    input  logic [JOINT_W-1:0]             i_res_joint,
    input  logic [ERR_W-1:0]               i_res_error_bits,
    input  logic                           i_res_violation,
    input  logic                           i_res_stop_request,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [SAMPLE_WIDTH-1:0] vel_limit [JOINT_COUNT];
    logic signed [SAMPLE_WIDTH-1:0] cur_limit [JOINT_COUNT];
    logic [ERR_W-1:0]               err_word  [JOINT_COUNT];
    logic                           latched;
    logic                           stop_sent;
    logic [CNT_W-1:0]               fail_run;
    logic [CNT_W-1:0]               fail_limit;

    t_result pending_reports [$];
    int      mismatches;

    function automatic int magnitude(input logic signed [SAMPLE_WIDTH-1:0] v);
        int wide;
        wide = int'(v);
        return (wide < 0) ? -wide : wide;
    endfunction

    function automatic t_result predict_report(input t_req req,
                                               input logic [JOINT_W-1:0] jnt,
                                               input logic signed [SAMPLE_WIDTH-1:0] vel,
                                               input logic signed [SAMPLE_WIDTH-1:0] cur,
                                               input logic [HW_W-1:0] hw);
        t_result          rep;
        logic [ERR_W-1:0] word;
        logic [CNT_W:0]   next_run;
        logic             known;
        rep = '0;
        rep.joint_out = jnt;
        known = (int'(jnt) < JOINT_COUNT);

        // stop is judged against the latch as it stood on arrival
        if (req == REQ_SAMPLE || req == REQ_READ_FAIL) begin
            if (latched) begin
                if (!stop_sent) begin
                    rep.stop_request = 1'b1;
                    stop_sent = 1'b1;
                end
            end else begin
                stop_sent = 1'b0;
            end
        end

        case (req)
            REQ_SAMPLE: begin
                if (known) begin
                    word = err_word[jnt] | ERR_W'(hw);
                    if (hw != '0)
                        latched = 1'b1;
                    if (magnitude(vel) > int'(vel_limit[jnt])) begin
                        latched = 1'b1;
                        word[ERR_VEL_BIT] = 1'b1;
                    end
                    if (magnitude(cur) > int'(cur_limit[jnt])) begin
                        latched = 1'b1;
                        word[ERR_CUR_BIT] = 1'b1;
                    end
                    err_word[jnt] = word;
                    fail_run = '0;
                    rep.error_bits = word;
                end
            end
            REQ_READ_FAIL: begin
                rep.joint_out = '0;
                if (!latched) begin
                    next_run = {1'b0, fail_run} + 1'b1;
                    if (next_run > {1'b0, fail_limit}) begin
                        latched = 1'b1;
                        err_word[0][ERR_UNREACH_BIT] = 1'b1;
                        fail_run = '0;
                    end else begin
                        fail_run = next_run[CNT_W-1:0];
                    end
                end
                rep.error_bits = err_word[0];
            end
            REQ_RESET: begin
                foreach (err_word[k])
                    err_word[k] = '0;
                latched = 1'b0;
                rep.joint_out = '0;
            end
            REQ_LOAD: begin
                if (known) begin
                    vel_limit[jnt] = vel;
                    cur_limit[jnt] = cur;
                    rep.error_bits = err_word[jnt];
                end
            end
            default: begin
                rep.joint_out = jnt;
            end
        endcase
        rep.violation = latched;
        return rep;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_result want;
        if (!i_rst_n) begin
            foreach (err_word[k]) begin
                err_word[k]  = '0;
                vel_limit[k] = '0;
                cur_limit[k] = '0;
            end
            latched    = 1'b0;
            stop_sent  = 1'b0;
            fail_run   = '0;
            fail_limit = READ_FAIL_LIMIT_RST;
            pending_reports.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                fail_limit = i_cfg_data;

            // check the report leaving before queueing the request entering
            if (i_res_valid && !i_res_stall) begin
                if (pending_reports.size() == 0) begin
                    $error("report with no request outstanding: joint_out %0d error_bits %h",
                           i_res_joint, i_res_error_bits);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    if (i_res_joint !== want.joint_out) begin
                        $error("joint_out: expected %0d, got %0d", want.joint_out, i_res_joint);
                        mismatches++;
                    end
                    if (i_res_error_bits !== want.error_bits) begin
                        $error("error_bits: expected %h, got %h",
                               want.error_bits, i_res_error_bits);
                        mismatches++;
                    end
                    if (i_res_violation !== want.violation) begin
                        $error("violation: expected %b, got %b",
                               want.violation, i_res_violation);
                        mismatches++;
                    end
                    if (i_res_stop_request !== want.stop_request) begin
                        $error("stop_request: expected %b, got %b",
                               want.stop_request, i_res_stop_request);
                        mismatches++;
                    end
                end
            end

            if (i_req_valid && !i_req_stall)
                pending_reports.push_back(predict_report(t_req'(i_req_type), i_joint,
                                                         i_velocity, i_motor_current,
                                                         i_hw_error));
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_reports.size();
    end

endmodule

/* verif/tb_top.sv */
// Testbench top: clock, reset, request and limit stimulus, result back-pressure, verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import jslm_pkg::*;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [1:0]                     i_req_type;
    logic [JOINT_W-1:0]             i_joint;
    logic signed [SAMPLE_WIDTH-1:0] i_velocity;
    logic signed [SAMPLE_WIDTH-1:0] i_motor_current;
    logic [HW_W-1:0]                i_hw_error;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [CNT_W-1:0]               i_cfg_data;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [JOINT_W-1:0]             o_joint_out;
    logic [ERR_W-1:0]               o_error_bits;
    logic                           o_violation;
    logic                           o_stop_request;

    int          fail_count;
    int          pending;
    int unsigned requests_sent = 0;
    int unsigned stall_left = 0;
    logic        tx_quiet = 1'b0;
    logic        rx_quiet = 1'b0;

    joint_safety_limit_monitor_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_joint        (i_joint),
        .i_velocity     (i_velocity),
        .i_motor_current(i_motor_current),
        .i_hw_error     (i_hw_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_joint_out    (o_joint_out),
        .o_error_bits   (o_error_bits),
        .o_violation    (o_violation),
        .o_stop_request (o_stop_request)
    );

    jslm_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_valid),
        .i_req_stall       (o_stall),
        .i_req_type        (i_req_type),
        .i_joint           (i_joint),
        .i_velocity        (i_velocity),
        .i_motor_current   (i_motor_current),
        .i_hw_error        (i_hw_error),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_res_joint       (o_joint_out),
        .i_res_error_bits  (o_error_bits),
        .i_res_violation   (o_violation),
        .i_res_stop_request(o_stop_request),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // after each report taken, randomly hold the output off with i_stall unless rx_quiet is set
    always @(posedge i_clk) begin : result_backpressure
        int unsigned hold;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= (stall_left > 1);
        end else if (o_valid && !i_stall) begin
            hold = rx_quiet ? 0 : $urandom_range(0, 3);
            stall_left <= hold;
            i_stall    <= (hold != 0);
        end
    end

    task automatic send_req(input t_req req, input logic [JOINT_W-1:0] jnt,
                            input logic signed [SAMPLE_WIDTH-1:0] vel,
                            input logic signed [SAMPLE_WIDTH-1:0] cur,
                            input logic [HW_W-1:0] hw);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_req_type      <= req;
        i_joint         <= jnt;
        i_velocity      <= vel;
        i_motor_current <= cur;
        i_hw_error      <= hw;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_fail_limit(input logic [CNT_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [JOINT_W-1:0] any_joint();
        return JOINT_W'($urandom);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] any_sample();
        return SAMPLE_WIDTH'($urandom);
    endfunction

    function automatic logic [HW_W-1:0] any_hw();
        return HW_W'($urandom);
    endfunction

    // mostly modest magnitudes so that limits are not hit on every sample
    function automatic logic signed [SAMPLE_WIDTH-1:0] sample_value();
        int unsigned roll;
        logic signed [SAMPLE_WIDTH-1:0] v;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 3))
                0: v = 16'sh8000;
                1: v = 16'sh7FFF;
                2: v = '0;
                default: v = -16'sd1;
            endcase
        end else if (roll < 3) begin
            v = SAMPLE_WIDTH'($urandom);
        end else begin
            v = SAMPLE_WIDTH'($urandom_range(0, 3000));
            if ($urandom_range(0, 1) != 0)
                v = -v;
        end
        return v;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] limit_value();
        int unsigned roll;
        logic signed [SAMPLE_WIDTH-1:0] v;
        roll = $urandom_range(0, 9);
        case (roll)
            0: v = '0;
            1: v = SAMPLE_WIDTH'($urandom);
            2: v = 16'sh7FFF;
            3: v = -16'sd1;
            default: v = SAMPLE_WIDTH'($urandom_range(3000, 32767));
        endcase
        return v;
    endfunction

    function automatic logic [HW_W-1:0] hw_value();
        return ($urandom_range(0, 6) == 0) ? HW_W'($urandom_range(1, 255)) : '0;
    endfunction

    // clear the latch, then a run of read failures, optionally broken by a sample
    task automatic fail_burst(input int unsigned n, input int unsigned break_at);
        send_req(REQ_RESET, any_joint(), any_sample(), any_sample(), any_hw());
        for (int unsigned k = 0; k < n; k++) begin
            if (k == break_at)
                send_req(REQ_SAMPLE, any_joint(), sample_value(), sample_value(), '0);
            send_req(REQ_READ_FAIL, any_joint(), any_sample(), any_sample(), any_hw());
        end
    endtask

    task automatic run_directed();
        send_req(REQ_LOAD, 3'd0, 16'sh7FFF, 16'sh7FFF, '0);
        send_req(REQ_LOAD, 3'd1, '0, '0, '0);
        send_req(REQ_LOAD, 3'd2, 16'sh8000, 16'sh8000, 8'hFF);
        send_req(REQ_LOAD, 3'd3, 16'sd100, 16'sd200, '0);
        send_req(REQ_LOAD, 3'd4, 16'sh7FFF, '0, '0);
        send_req(REQ_LOAD, 3'd5, 16'sd20000, 16'sd20000, '0);
        send_req(REQ_LOAD, 3'd6, 16'sd20000, 16'sd20000, '0);
        send_req(REQ_LOAD, 3'd7, 16'sd20000, 16'sd20000, '0);
        // most negative velocity has magnitude 32768, just above the top limit
        send_req(REQ_SAMPLE, 3'd0, 16'sh8000, 16'sh7FFF, '0);
        send_req(REQ_SAMPLE, 3'd0, '0, '0, '0);
        send_req(REQ_READ_FAIL, 3'd5, '0, '0, '0);
        send_req(REQ_RESET, 3'd7, -16'sd1, -16'sd1, 8'hFF);
        send_req(REQ_SAMPLE, 3'd0, 16'sh7FFF, -16'sd32767, '0);
        // exactly at the limit is not a violation
        send_req(REQ_SAMPLE, 3'd3, -16'sd100, 16'sd200, '0);
        send_req(REQ_SAMPLE, 3'd3, 16'sd101, -16'sd201, 8'h80);
        send_req(REQ_SAMPLE, 3'd1, '0, '0, '0);
        send_req(REQ_RESET, '0, '0, '0, '0);
        send_req(REQ_SAMPLE, 3'd2, '0, '0, '0);
        send_req(REQ_RESET, '0, '0, '0, '0);
        send_req(REQ_SAMPLE, 3'd7, -16'sd20000, 16'sd20000, 8'h01);
    endtask

    task automatic run_random(input int unsigned lim, input int unsigned count);
        int unsigned first;
        int unsigned pick;
        int unsigned n;
        first = requests_sent;
        while (requests_sent - first < count) begin
            if ($urandom_range(0, 31) == 0) begin
                tx_quiet = ($urandom_range(0, 2) == 0);
                rx_quiet <= ($urandom_range(0, 2) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 44) begin
                send_req(REQ_SAMPLE, any_joint(), sample_value(), sample_value(), hw_value());
            end else if (pick < 54) begin
                send_req(REQ_LOAD, any_joint(), limit_value(), limit_value(), any_hw());
            end else if (pick < 61) begin
                send_req(REQ_RESET, any_joint(), any_sample(), any_sample(), any_hw());
            end else if (pick < 69) begin
                send_req(REQ_READ_FAIL, any_joint(), any_sample(), any_sample(), any_hw());
            end else if (pick < 82) begin
                n = (lim > 40) ? $urandom_range(1, 20) : lim + $urandom_range(0, 2);
                fail_burst(n, ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n + 1);
            end else begin
                send_req(t_req'($urandom_range(0, 3)), any_joint(), any_sample(),
                         any_sample(), any_hw());
            end
        end
    endtask

    initial begin : stimulus
        int unsigned lim;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_req_type      <= REQ_SAMPLE;
        i_joint         <= '0;
        i_velocity      <= '0;
        i_motor_current <= '0;
        i_hw_error      <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every limit entry is loaded here before any sample reads one
        run_directed();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: lim = 32'(READ_FAIL_LIMIT_RST);
                1: lim = 0;
                2: lim = 255;
                3: lim = 3;
                4: lim = $urandom_range(1, 40);
                default: lim = 1;
            endcase
            if (ph != 0)
                write_fail_limit(CNT_W'(lim));
            // at the top limit the 256th failure in a row latches
            if (lim == 255)
                fail_burst(257, 258);
            run_random(lim, 250);
        end

        wait_idle();
        repeat (6) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* joint_safety_limit_monitor_top.f */
sv/jslm_pkg.sv
sv/jslm_limit_check.sv
sv/jslm_err_state.sv
sv/joint_safety_limit_monitor_top.sv
verif/jslm_checker.sv
verif/tb_top.sv
